// ----- rtl/double_integrator_pd_tracking_step_assert.svh -----
// assertion macros for the pd tracking step block
// no dependencies; included by the top level only
`ifndef DOUBLE_INTEGRATOR_PD_TRACKING_STEP_ASSERT_SVH
`define DOUBLE_INTEGRATOR_PD_TRACKING_STEP_ASSERT_SVH

// same-cycle implication
`define DIPD_ASSERT_IMP(LBL, CLK, RSTN, ANT, CON, MSG) \
    LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANT) |-> (CON)) \
        else $error(MSG);

// next-cycle implication
`define DIPD_ASSERT_NXT(LBL, CLK, RSTN, ANT, CON, MSG) \
    LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANT) |=> (CON)) \
        else $error(MSG);

`endif

// ----- rtl/dipd_pkg.sv -----
// shared types, constants and helper functions of the pd tracking step block
// no dependencies; imported by the sequencer, the datapath and the top level
`timescale 1ns / 1ps

package dipd_pkg;

    localparam int NUM_AXES     = 4;
    localparam int FRAC_BITS    = 16;
    localparam int AXIS_W       = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
    localparam int N_OUT        = 4;

    localparam int X_AXIS       = 0;
    localparam int Y_AXIS       = 1;
    localparam int HEADING_AXIS = 3;

    localparam int Q_W     = 32;
    localparam int DT_W    = 16;
    localparam int GAIN_W  = 21;
    localparam int LIM_W   = 27;
    localparam int COEF_W  = 21;
    localparam int DIFF_W  = Q_W + 1;
    localparam int MUL_B_W = GAIN_W + 1;
    localparam int PROD_W  = DIFF_W + MUL_B_W;
    localparam int ACC_W   = PROD_W + 2;
    localparam int RND_W   = ACC_W - FRAC_BITS;
    localparam int SUM_W   = RND_W + 1;
    localparam int PC_W    = 5;
    localparam int CFG_IDX_W = 3;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POS_GAIN      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VEL_GAIN      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_START_X       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_START_Y       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_START_HEADING = 3'd6;

    // config reset values
    localparam logic [DT_W-1:0]   RST_STEP_TIME   = 16'd655;
    localparam logic [GAIN_W-1:0] RST_POS_GAIN    = 21'd131072;
    localparam logic [GAIN_W-1:0] RST_VEL_GAIN    = 21'd52429;
    localparam logic [LIM_W-1:0]  RST_SPEED_LIMIT = 27'd32768;

    // first step of the per-axis loop in the microprogram
    localparam logic [PC_W-1:0] LOOP_PC = 5'd7;

    typedef enum logic [1:0] {
        ACT_COMMAND = 2'd0,
        ACT_TICK    = 2'd1,
        ACT_RESTART = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        MA_DT  = 3'd0,
        MA_DT2 = 3'd1,
        MA_RV  = 3'd2,
        MA_V   = 3'd3,
        MA_EP  = 3'd4,
        MA_EV  = 3'd5
    } mul_a_sel_t;

    typedef enum logic [2:0] {
        MB_DT = 3'd0,
        MB_KP = 3'd1,
        MB_KD = 3'd2,
        MB_CA = 3'd3,
        MB_CB = 3'd4,
        MB_CC = 3'd5,
        MB_CD = 3'd6
    } mul_b_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD = 2'd0,
        ACC_LOAD = 2'd1,
        ACC_ADD  = 2'd2
    } acc_op_t;

    typedef enum logic [3:0] {
        WB_NONE = 4'd0,
        WB_DT2  = 4'd1,
        WB_C    = 4'd2,
        WB_D    = 4'd3,
        WB_A    = 4'd4,
        WB_B    = 4'd5,
        WB_RP   = 4'd6,
        WB_P    = 4'd7,
        WB_V    = 4'd8
    } wb_sel_t;

    typedef enum logic [1:0] {
        JMP_NEXT = 2'd0,
        JMP_AXIS = 2'd1,
        JMP_EMIT = 2'd2
    } jmp_t;

    // one microcode word
    typedef struct packed {
        mul_a_sel_t       ma;
        mul_b_sel_t       mb;
        acc_op_t          acc;
        wb_sel_t          wb;
        logic             diff;
        jmp_t             jmp;
        logic [PC_W-1:0]  target;
    } ucw_t;

    localparam ucw_t UCW_NOP = '{ma: MA_DT, mb: MB_DT, acc: ACC_HOLD, wb: WB_NONE,
                                 diff: 1'b0, jmp: JMP_NEXT, target: '0};

    // sequencer to datapath
    typedef struct packed {
        ucw_t              uw;
        logic [AXIS_W-1:0] axis;
        logic              emit;
    } ctl_t;

    // state loads done at accept time
    typedef struct packed {
        logic command;
        logic restart;
    } dp_cmd_t;

    typedef struct packed {
        logic [DT_W-1:0]    step_time;
        logic [GAIN_W-1:0]  pos_gain;
        logic [GAIN_W-1:0]  vel_gain;
        logic [LIM_W-1:0]   speed_limit;
        logic signed [Q_W-1:0] start_x;
        logic signed [Q_W-1:0] start_y;
        logic signed [Q_W-1:0] start_heading;
    } cfg_t;

    // saturate to the signed 32 bit range
    function automatic logic signed [Q_W-1:0] sat32(input logic signed [SUM_W-1:0] x);
        logic signed [Q_W-1:0] r;
        if (!x[SUM_W-1] && (|x[SUM_W-2:Q_W-1])) begin
            r = {1'b0, {(Q_W-1){1'b1}}};
        end else if (x[SUM_W-1] && !(&x[SUM_W-2:Q_W-1])) begin
            r = {1'b1, {(Q_W-1){1'b0}}};
        end else begin
            r = x[Q_W-1:0];
        end
        return r;
    endfunction

    // symmetric clamp of a command to +-lim
    function automatic logic signed [Q_W-1:0] clamp_cmd(input logic signed [Q_W-1:0] v,
                                                        input logic [LIM_W-1:0] lim);
        logic signed [Q_W:0] xs;
        logic signed [Q_W:0] ls;
        logic signed [Q_W:0] nl;
        logic signed [Q_W-1:0] r;
        xs = {v[Q_W-1], v};
        ls = signed'({{(Q_W+1-LIM_W){1'b0}}, lim});
        nl = -ls;
        if (xs > ls) begin
            r = ls[Q_W-1:0];
        end else if (xs < nl) begin
            r = nl[Q_W-1:0];
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ----- rtl/dipd_sequencer.sv -----
// microcode sequencer: step counter, axis counter, control store and jumps
// depends on dipd_pkg
`timescale 1ns / 1ps

module dipd_sequencer
    import dipd_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic start,
    input  logic out_free,
    output logic idle,
    output ctl_t ctl
);

    typedef enum logic [1:0] {
        SEQ_IDLE = 2'b01,
        SEQ_RUN  = 2'b10
    } seq_state_t;

    localparam logic [AXIS_W-1:0] LAST_AXIS = AXIS_W'(NUM_AXES - 1);

    seq_state_t        state_reg, state_next;
    logic [PC_W-1:0]   pc_reg, pc_next;
    logic [AXIS_W-1:0] axis_reg, axis_next;
    ucw_t              uw;
    logic              run;

    // control store
    function automatic ucw_t rom(input logic [PC_W-1:0] a);
        ucw_t w;
        w = UCW_NOP;
        case (a)
            5'd0: begin  // dt*dt
                w.ma = MA_DT;  w.mb = MB_DT;
            end
            5'd1: begin  // dt*kp
                w.acc = ACC_LOAD; w.ma = MA_DT; w.mb = MB_KP;
            end
            5'd2: begin  // dt*kd
                w.wb = WB_DT2; w.acc = ACC_LOAD; w.ma = MA_DT; w.mb = MB_KD;
            end
            5'd3: begin  // dt2*kp
                w.wb = WB_C; w.acc = ACC_LOAD; w.ma = MA_DT2; w.mb = MB_KP;
            end
            5'd4: begin  // dt2*kd
                w.wb = WB_D; w.acc = ACC_LOAD; w.ma = MA_DT2; w.mb = MB_KD;
            end
            5'd5: begin
                w.wb = WB_A; w.acc = ACC_LOAD;
            end
            5'd6: begin
                w.wb = WB_B;
            end
            5'd7: begin  // axis loop: dt*rv
                w.ma = MA_RV; w.mb = MB_DT;
            end
            5'd8: begin
                w.acc = ACC_LOAD;
            end
            5'd9: begin
                w.wb = WB_RP;
            end
            5'd10: begin  // errors, dt*v
                w.diff = 1'b1; w.ma = MA_V; w.mb = MB_DT;
            end
            5'd11: begin
                w.acc = ACC_LOAD; w.ma = MA_EP; w.mb = MB_CA;
            end
            5'd12: begin
                w.acc = ACC_ADD; w.ma = MA_EV; w.mb = MB_CB;
            end
            5'd13: begin
                w.acc = ACC_ADD; w.ma = MA_EP; w.mb = MB_CC;
            end
            5'd14: begin
                w.wb = WB_P; w.acc = ACC_LOAD; w.ma = MA_EV; w.mb = MB_CD;
            end
            5'd15: begin
                w.acc = ACC_ADD;
            end
            5'd16: begin
                w.wb = WB_V; w.jmp = JMP_AXIS; w.target = LOOP_PC;
            end
            5'd17: begin
                w.jmp = JMP_EMIT;
            end
            default: begin
                w = UCW_NOP;
            end
        endcase
        return w;
    endfunction

    assign uw   = rom(pc_reg);
    assign run  = (state_reg == SEQ_RUN);
    assign idle = (state_reg == SEQ_IDLE);

    always_comb begin
        ctl.uw   = run ? uw : UCW_NOP;
        ctl.axis = axis_reg;
        ctl.emit = run && (uw.jmp == JMP_EMIT) && out_free;
    end

    always_comb begin
        state_next = state_reg;
        pc_next    = pc_reg;
        axis_next  = axis_reg;
        case (state_reg)
            SEQ_IDLE: begin
                if (start) begin
                    state_next = SEQ_RUN;
                    pc_next    = '0;
                    axis_next  = '0;
                end
            end
            SEQ_RUN: begin
                case (uw.jmp)
                    JMP_NEXT: begin
                        pc_next = pc_reg + 1'b1;
                    end
                    JMP_AXIS: begin
                        if (axis_reg == LAST_AXIS) begin
                            pc_next = pc_reg + 1'b1;
                        end else begin
                            axis_next = axis_reg + 1'b1;
                            pc_next   = uw.target;
                        end
                    end
                    JMP_EMIT: begin
                        if (out_free) begin
                            state_next = SEQ_IDLE;
                        end
                    end
                    default: begin
                        state_next = SEQ_IDLE;
                    end
                endcase
            end
            default: begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SEQ_IDLE;
            pc_reg    <= '0;
            axis_reg  <= '0;
        end else begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            axis_reg  <= axis_next;
        end
    end

endmodule

// ----- rtl/dipd_datapath.sv -----
// datapath: axis state, shared multiplier, accumulator, rounding and saturation
// depends on dipd_pkg; driven by dipd_sequencer control words
`timescale 1ns / 1ps

module dipd_datapath
    import dipd_pkg::*;
(
    input  logic                          aclk,
    input  logic                          aresetn,
    input  cfg_t                          cfg,
    input  ctl_t                          ctl,
    input  dp_cmd_t                       cmd,
    input  logic signed [Q_W-1:0]         cmd_vx,
    input  logic signed [Q_W-1:0]         cmd_vy,
    input  logic signed [Q_W-1:0]         cmd_yaw_rate,
    output logic [N_OUT-1:0][Q_W-1:0]     pose
);

    localparam logic signed [ACC_W:0] HALF_F = (ACC_W+1)'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [ACC_W:0] HALF_A = (ACC_W+1)'(1) <<< (2 * FRAC_BITS);

    logic signed [Q_W-1:0] pos_reg  [NUM_AXES];
    logic signed [Q_W-1:0] vel_reg  [NUM_AXES];
    logic signed [Q_W-1:0] rpos_reg [NUM_AXES];
    logic signed [Q_W-1:0] rvel_reg [NUM_AXES];

    logic [Q_W-1:0]           dt2_reg;
    logic [COEF_W-1:0]        ca_reg, cb_reg, cc_reg, cd_reg;
    logic signed [DIFF_W-1:0] ep_reg, ev_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    logic signed [DIFF_W-1:0]  op_a;
    logic signed [MUL_B_W-1:0] op_b;
    logic signed [ACC_W-1:0]   prod_ext;
    logic signed [ACC_W:0]     acc_ext;
    logic signed [ACC_W:0]     rnd_f_full, rnd_a_full;
    logic signed [RND_W-1:0]   rnd_f;
    logic signed [Q_W-1:0]     base;
    logic signed [SUM_W-1:0]   wb_sum;
    logic signed [Q_W-1:0]     wb_sat;

    logic signed [Q_W-1:0] p_ax, v_ax, rp_ax, rv_ax;

    assign p_ax  = pos_reg[ctl.axis];
    assign v_ax  = vel_reg[ctl.axis];
    assign rp_ax = rpos_reg[ctl.axis];
    assign rv_ax = rvel_reg[ctl.axis];

    // multiplier operands
    always_comb begin
        case (ctl.uw.ma)
            MA_DT:   op_a = signed'({{(DIFF_W-DT_W){1'b0}}, cfg.step_time});
            MA_DT2:  op_a = signed'({1'b0, dt2_reg});
            MA_RV:   op_a = {rv_ax[Q_W-1], rv_ax};
            MA_V:    op_a = {v_ax[Q_W-1], v_ax};
            MA_EP:   op_a = ep_reg;
            MA_EV:   op_a = ev_reg;
            default: op_a = '0;
        endcase
        case (ctl.uw.mb)
            MB_DT:   op_b = signed'({{(MUL_B_W-DT_W){1'b0}}, cfg.step_time});
            MB_KP:   op_b = signed'({1'b0, cfg.pos_gain});
            MB_KD:   op_b = signed'({1'b0, cfg.vel_gain});
            MB_CA:   op_b = signed'({1'b0, ca_reg});
            MB_CB:   op_b = signed'({1'b0, cb_reg});
            MB_CC:   op_b = signed'({1'b0, cc_reg});
            MB_CD:   op_b = signed'({1'b0, cd_reg});
            default: op_b = '0;
        endcase
    end

    assign prod_ext = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    assign acc_ext  = {acc_reg[ACC_W-1], acc_reg};

    // round half up, then floor
    assign rnd_f_full = (acc_ext + HALF_F) >>> FRAC_BITS;
    assign rnd_a_full = (acc_ext + HALF_A) >>> (2 * FRAC_BITS + 1);
    assign rnd_f      = rnd_f_full[RND_W-1:0];

    always_comb begin
        case (ctl.uw.wb)
            WB_RP:   base = rp_ax;
            WB_P:    base = p_ax;
            WB_V:    base = v_ax;
            default: base = '0;
        endcase
    end

    assign wb_sum = {{(SUM_W-Q_W){base[Q_W-1]}}, base} + {rnd_f[RND_W-1], rnd_f};
    assign wb_sat = sat32(wb_sum);

    // arithmetic pipeline, no reset needed
    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
        case (ctl.uw.acc)
            ACC_LOAD: acc_reg <= prod_ext;
            ACC_ADD:  acc_reg <= acc_reg + prod_ext;
            default:  acc_reg <= acc_reg;
        endcase
        case (ctl.uw.wb)
            WB_DT2:  dt2_reg <= acc_reg[Q_W-1:0];
            WB_C:    cc_reg  <= rnd_f_full[COEF_W-1:0];
            WB_D:    cd_reg  <= rnd_f_full[COEF_W-1:0];
            WB_A:    ca_reg  <= rnd_a_full[COEF_W-1:0];
            WB_B:    cb_reg  <= rnd_a_full[COEF_W-1:0];
            default: ;
        endcase
        if (ctl.uw.diff) begin
            ep_reg <= {rp_ax[Q_W-1], rp_ax} - {p_ax[Q_W-1], p_ax};
            ev_reg <= {rv_ax[Q_W-1], rv_ax} - {v_ax[Q_W-1], v_ax};
        end
    end

    // axis state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                pos_reg[i]  <= '0;
                vel_reg[i]  <= '0;
                rpos_reg[i] <= '0;
                rvel_reg[i] <= '0;
            end
        end else if (cmd.restart) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                pos_reg[i]  <= (i == X_AXIS) ? cfg.start_x :
                               (i == Y_AXIS) ? cfg.start_y : '0;
                vel_reg[i]  <= '0;
                rpos_reg[i] <= (i == X_AXIS) ? cfg.start_x :
                               (i == Y_AXIS) ? cfg.start_y :
                               (i == HEADING_AXIS) ? cfg.start_heading : '0;
                rvel_reg[i] <= '0;
            end
        end else if (cmd.command) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                rpos_reg[i] <= pos_reg[i];
                rvel_reg[i] <= (i == X_AXIS) ? clamp_cmd(cmd_vx, cfg.speed_limit) :
                               (i == Y_AXIS) ? clamp_cmd(cmd_vy, cfg.speed_limit) :
                               (i == HEADING_AXIS) ?
                                   clamp_cmd(cmd_yaw_rate, cfg.speed_limit) : '0;
            end
        end else begin
            case (ctl.uw.wb)
                WB_RP:   rpos_reg[ctl.axis] <= wb_sat;
                WB_P:    pos_reg[ctl.axis]  <= wb_sat;
                WB_V:    vel_reg[ctl.axis]  <= wb_sat;
                default: ;
            endcase
        end
    end

    for (genvar k = 0; k < N_OUT; k++) begin : g_pose
        if (k < NUM_AXES) begin : g_on
            assign pose[k] = pos_reg[k];
        end else begin : g_off
            assign pose[k] = '0;
        end
    end

endmodule

// ----- rtl/double_integrator_pd_tracking_step.sv -----
// top level of the four-axis pd tracking step block
// depends on dipd_pkg, dipd_sequencer, dipd_datapath and the assertion macro header
//
//  channel   ports                                         role
//  s_        s_valid s_ready s_action s_cmd_vx s_cmd_vy    command, tick or restart
//            s_cmd_yaw_rate
//  m_        m_valid m_ready m_pos_x m_pos_y m_pos_z       pose after each tick
//            m_heading
//  cfg_      cfg_we cfg_addr cfg_wdata                     register writes, no wait
//
//  a command or restart transaction updates the state in the accept cycle
//  a tick runs the microprogram after accept; the single shared multiplier is stepped
//  through the coefficient steps once and then through the same loop for each axis
//  the input is not ready while a tick runs; the last step waits if a pose is still held
//  reset is synchronous active low and restores register defaults and zero state
`timescale 1ns / 1ps
`include "double_integrator_pd_tracking_step_assert.svh"

module double_integrator_pd_tracking_step
    import dipd_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,

    // register write port
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_addr,
    input  logic [Q_W-1:0]         cfg_wdata,

    // input transactions
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [1:0]             s_action,
    input  logic signed [Q_W-1:0]  s_cmd_vx,
    input  logic signed [Q_W-1:0]  s_cmd_vy,
    input  logic signed [Q_W-1:0]  s_cmd_yaw_rate,

    // result transactions
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic signed [Q_W-1:0]  m_pos_x,
    output logic signed [Q_W-1:0]  m_pos_y,
    output logic signed [Q_W-1:0]  m_pos_z,
    output logic signed [Q_W-1:0]  m_heading
);

    // configuration registers
    logic [DT_W-1:0]       step_time_reg;
    logic [GAIN_W-1:0]     pos_gain_reg;
    logic [GAIN_W-1:0]     vel_gain_reg;
    logic [LIM_W-1:0]      speed_limit_reg;
    logic signed [Q_W-1:0] start_x_reg;
    logic signed [Q_W-1:0] start_y_reg;
    logic signed [Q_W-1:0] start_heading_reg;
    cfg_t                  cfg;

    // handshake and control
    logic    s_accept;
    action_t action;
    logic    seq_idle;
    logic    out_free;
    ctl_t    ctl;
    dp_cmd_t cmd;

    logic [N_OUT-1:0][Q_W-1:0] pose;

    // output register
    logic                  m_valid_reg;
    logic signed [Q_W-1:0] pos_x_reg, pos_y_reg, pos_z_reg, heading_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_time_reg     <= RST_STEP_TIME;
            pos_gain_reg      <= RST_POS_GAIN;
            vel_gain_reg      <= RST_VEL_GAIN;
            speed_limit_reg   <= RST_SPEED_LIMIT;
            start_x_reg       <= '0;
            start_y_reg       <= '0;
            start_heading_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_STEP_TIME:     step_time_reg     <= cfg_wdata[DT_W-1:0];
                REG_POS_GAIN:      pos_gain_reg      <= cfg_wdata[GAIN_W-1:0];
                REG_VEL_GAIN:      vel_gain_reg      <= cfg_wdata[GAIN_W-1:0];
                REG_SPEED_LIMIT:   speed_limit_reg   <= cfg_wdata[LIM_W-1:0];
                REG_START_X:       start_x_reg       <= cfg_wdata;
                REG_START_Y:       start_y_reg       <= cfg_wdata;
                REG_START_HEADING: start_heading_reg <= cfg_wdata;
                default: ;  // unknown index, write dropped
            endcase
        end
    end

    always_comb begin
        cfg.step_time     = step_time_reg;
        cfg.pos_gain      = pos_gain_reg;
        cfg.vel_gain      = vel_gain_reg;
        cfg.speed_limit   = speed_limit_reg;
        cfg.start_x       = start_x_reg;
        cfg.start_y       = start_y_reg;
        cfg.start_heading = start_heading_reg;
    end

    // input side: ready whenever no tick program is running
    assign s_ready  = seq_idle;
    assign s_accept = s_valid && s_ready;
    assign action   = action_t'(s_action);

    // command and restart are direct state loads; unused action code does nothing
    always_comb begin
        cmd.command = 1'b0;
        cmd.restart = 1'b0;
        case (action)
            ACT_COMMAND: cmd.command = s_accept;
            ACT_RESTART: cmd.restart = s_accept;
            default: ;
        endcase
    end

    // the pose may be loaded when the holding register is empty or being drained
    assign out_free = !m_valid_reg || m_ready;

    dipd_sequencer u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (s_accept && (action == ACT_TICK)),
        .out_free (out_free),
        .idle     (seq_idle),
        .ctl      (ctl)
    );

    dipd_datapath u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .ctl          (ctl),
        .cmd          (cmd),
        .cmd_vx       (s_cmd_vx),
        .cmd_vy       (s_cmd_vy),
        .cmd_yaw_rate (s_cmd_yaw_rate),
        .pose         (pose)
    );

    // result holding register, decouples the result side from the next transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctl.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.emit) begin
            pos_x_reg   <= pose[0];
            pos_y_reg   <= pose[1];
            pos_z_reg   <= pose[2];
            heading_reg <= pose[3];
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_pos_x   = pos_x_reg;
    assign m_pos_y   = pos_y_reg;
    assign m_pos_z   = pos_z_reg;
    assign m_heading = heading_reg;

    // a pose is never loaded over one that is still waiting
    `DIPD_ASSERT_IMP(a_emit_room, aclk, aresetn, ctl.emit, (!m_valid_reg || m_ready), "pose loaded over a held result")
    // a tick blocks the input on the following cycle
    `DIPD_ASSERT_NXT(a_tick_busy, aclk, aresetn, (s_valid && s_ready && (s_action == ACT_TICK)), !s_ready, "input ready during tick")
    // every emit shows up as a valid result
    `DIPD_ASSERT_NXT(a_emit_valid, aclk, aresetn, ctl.emit, m_valid, "emitted pose not presented")
    // axis counter stays within the axes
    `DIPD_ASSERT_IMP(a_axis_range, aclk, aresetn, 1'b1, (ctl.axis <= AXIS_W'(NUM_AXES - 1)), "axis counter out of range")

endmodule
